@@ design/laser_scan_polar_to_cartesian_macros.svh @@
// Assertion macros used by the laser scan converter top level.
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define LSP2C_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsp2c: same-cycle check failed");

// Check a consequence in the cycle after its condition.
`define LSP2C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsp2c: next-cycle check failed");

`endif

@@ design/lsp2c_pkg.sv @@
// Shared types, constants and the rotation angle table of the laser scan converter.
package lsp2c_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int GUARD_BITS   = 24;
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_MIN_RANGE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_ANGLE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_USE_INTENSITY = 3'd4;

    localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    typedef struct packed {
        logic [1:0]  quadrant;
        logic [15:0] intensity;
    } lsp2c_side_t;

endpackage

@@ design/lsp2c_regs.sv @@
// Configuration register file behind the APB-style port.
module lsp2c_regs #(
    parameter int RANGE_BITS = 24,
    parameter int ANGLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsp2c_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [RANGE_BITS-1:0]               min_range,
    output logic [RANGE_BITS-1:0]               max_range,
    output logic [ANGLE_BITS-1:0]               start_angle,
    output logic [ANGLE_BITS-1:0]               angle_step,
    output logic                                use_intensity
);
    import lsp2c_pkg::*;

    logic [RANGE_BITS-1:0] min_range_reg;
    logic [RANGE_BITS-1:0] max_range_reg;
    logic [ANGLE_BITS-1:0] start_angle_reg;
    logic [ANGLE_BITS-1:0] angle_step_reg;
    logic                  use_intensity_reg;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg     <= '0;
            max_range_reg     <= '1;
            start_angle_reg   <= '0;
            angle_step_reg    <= '0;
            use_intensity_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_MIN_RANGE:     min_range_reg     <= pwdata[RANGE_BITS-1:0];
                REG_MAX_RANGE:     max_range_reg     <= pwdata[RANGE_BITS-1:0];
                REG_START_ANGLE:   start_angle_reg   <= pwdata[ANGLE_BITS-1:0];
                REG_ANGLE_STEP:    angle_step_reg    <= pwdata[ANGLE_BITS-1:0];
                REG_USE_INTENSITY: use_intensity_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIN_RANGE:     prdata = 32'(min_range_reg);
            REG_MAX_RANGE:     prdata = 32'(max_range_reg);
            REG_START_ANGLE:   prdata = 32'(start_angle_reg);
            REG_ANGLE_STEP:    prdata = 32'(angle_step_reg);
            REG_USE_INTENSITY: prdata = 32'(use_intensity_reg);
            default:           prdata = '0;
        endcase
    end

    assign min_range     = min_range_reg;
    assign max_range     = max_range_reg;
    assign start_angle   = start_angle_reg;
    assign angle_step    = angle_step_reg;
    assign use_intensity = use_intensity_reg;

endmodule

@@ design/lsp2c_cell.sv @@
// One rotation step of the CORDIC chain, registered toward the next cell.
module lsp2c_cell #(
    parameter int X_W  = 51,
    parameter int Z_W  = 34,
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         prev_valid,
    input  logic signed [X_W-1:0]        prev_x,
    input  logic signed [X_W-1:0]        prev_y,
    input  logic signed [Z_W-1:0]        prev_z,
    input  lsp2c_pkg::lsp2c_side_t       prev_side,
    output logic                         valid,
    output logic signed [X_W-1:0]        x,
    output logic signed [X_W-1:0]        y,
    output logic signed [Z_W-1:0]        z,
    output lsp2c_pkg::lsp2c_side_t       side
);
    import lsp2c_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = Z_W'(ATAN_TURNS[STEP]);

    logic                  valid_reg;
    logic signed [X_W-1:0] x_reg;
    logic signed [X_W-1:0] y_reg;
    logic signed [Z_W-1:0] z_reg;
    lsp2c_side_t           side_reg;
    logic signed [X_W-1:0] x_next;
    logic signed [X_W-1:0] y_next;
    logic signed [Z_W-1:0] z_next;
    logic signed [X_W-1:0] dx;
    logic signed [X_W-1:0] dy;

    always_comb
    begin
        dx = prev_y >>> STEP;
        dy = prev_x >>> STEP;
        if (!prev_z[Z_W-1])
        begin
            x_next = prev_x - dx;
            y_next = prev_y + dy;
            z_next = prev_z - ANGLE;
        end
        else
        begin
            x_next = prev_x + dx;
            y_next = prev_y - dy;
            z_next = prev_z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= prev_side;
        end
    end

    assign valid = valid_reg;
    assign x     = x_reg;
    assign y     = y_reg;
    assign z     = z_reg;
    assign side  = side_reg;

endmodule

@@ design/laser_scan_polar_to_cartesian.sv @@
// Laser scan beam to Cartesian point converter, top level.
//
// Takes one beam per cycle while s_tready is high on the slave stream and returns
// x = r*cos, y = r*sin on the master stream for every beam whose range lies in
// [min_range, max_range]; other beams advance the angle and give no point. The beam
// angle is start_angle when tuser flags the first beam of a scan, else the running
// accumulator. A beam passes an entry stage (gain multiply, quadrant fold), a chain
// of 32 rotation cells and a rounding/saturation output register before its point
// appears on m_tvalid; the chain sustains one beam per cycle unless m_tready holds it.
// While a point waits on m_tready low, the whole chain holds and s_tready drops.
// Registers: 0x00 min_range, 0x04 max_range, 0x08 start_angle, 0x0C angle_step,
// 0x10 use_intensity. Write them only while no beam is in flight.
module laser_scan_polar_to_cartesian #(
    parameter int RANGE_BITS = 24,
    parameter int ANGLE_BITS = 32,
    localparam int S_DATA_W = ((RANGE_BITS + 16 + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * (RANGE_BITS + 1) + 16 + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_DATA_W-1:0]               s_tdata,   // range, intensity
    input  logic [0:0]                        s_tuser,   // scan_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_DATA_W-1:0]               m_tdata,   // x_coord, y_coord, point_intensity
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsp2c_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lsp2c_pkg::*;

`include "laser_scan_polar_to_cartesian_macros.svh"

    localparam int X_W = RANGE_BITS + GUARD_BITS + 3;
    localparam int Z_W = 34;
    localparam int T_W = X_W - GUARD_BITS;
    localparam int P_W = RANGE_BITS + 32;
    localparam logic signed [X_W-1:0] RND    = X_W'(64'd1 << (GUARD_BITS - 1));
    localparam logic signed [T_W-1:0] SAT_HI = T_W'((64'd1 << RANGE_BITS) - 64'd1);
    localparam logic signed [T_W-1:0] SAT_LO = ~SAT_HI;

    logic [RANGE_BITS-1:0] min_range;
    logic [RANGE_BITS-1:0] max_range;
    logic [ANGLE_BITS-1:0] start_angle;
    logic [ANGLE_BITS-1:0] angle_step;
    logic                  use_intensity;

    logic [RANGE_BITS-1:0] in_range;
    logic [15:0]           in_intensity;
    logic                  in_window;
    logic                  adv;
    logic                  s_xfer;

    logic [ANGLE_BITS-1:0] angle_reg;
    logic [ANGLE_BITS-1:0] angle_next;
    logic [ANGLE_BITS-1:0] ang_sel;
    logic [31:0]           a32;
    logic [1:0]            quad;
    logic [31:0]           resid;
    logic [P_W-1:0]        prod;

    logic                  valid0_reg;
    logic signed [X_W-1:0] x0_reg;
    logic signed [Z_W-1:0] z0_reg;
    lsp2c_side_t           side0_reg;
    lsp2c_side_t           side0_next;

    logic [CORDIC_STEPS:0]  valid_vec;
    logic signed [X_W-1:0]  cx [CORDIC_STEPS+1];
    logic signed [X_W-1:0]  cy [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];
    lsp2c_side_t            cs [CORDIC_STEPS+1];

    logic signed [X_W-1:0]  xr;
    logic signed [X_W-1:0]  yr;
    logic                   m_valid_reg;
    logic [RANGE_BITS:0]    x_out_reg;
    logic [RANGE_BITS:0]    y_out_reg;
    logic [15:0]            inten_out_reg;

    function automatic logic [RANGE_BITS:0] finish(input logic signed [X_W-1:0] v);
        logic signed [X_W-1:0] sum;
        logic signed [T_W-1:0] t;
        sum = v + RND;
        t = T_W'(sum >>> GUARD_BITS);
        if (t > SAT_HI)
        begin
            t = SAT_HI;
        end
        else if (t < SAT_LO)
        begin
            t = SAT_LO;
        end
        return (RANGE_BITS + 1)'(t);
    endfunction

    lsp2c_regs #(
        .RANGE_BITS (RANGE_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .min_range     (min_range),
        .max_range     (max_range),
        .start_angle   (start_angle),
        .angle_step    (angle_step),
        .use_intensity (use_intensity)
    );

    // Hold the whole chain while the output register is full and not taken.
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_range     = s_tdata[RANGE_BITS-1:0];
    assign in_intensity = s_tdata[RANGE_BITS+15:RANGE_BITS];
    assign in_window    = (min_range <= in_range) && (in_range <= max_range);

    always_comb
    begin
        ang_sel    = s_tuser[0] ? start_angle : angle_reg;
        angle_next = ang_sel + angle_step;
        a32        = 32'(ang_sel) << (32 - ANGLE_BITS);
        quad       = 2'((a32 + 32'h2000_0000) >> 30);
        resid      = a32 - {quad, 30'b0};
        prod       = P_W'(in_range) * P_W'(GAIN_Q32);
        side0_next.quadrant  = quad;
        side0_next.intensity = use_intensity ? in_intensity : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg  <= '0;
            valid0_reg <= 1'b0;
        end
        else
        begin
            if (s_xfer)
            begin
                angle_reg <= angle_next;
            end
            if (adv)
            begin
                valid0_reg <= s_tvalid && in_window;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= X_W'(prod >> (32 - GUARD_BITS));
            z0_reg    <= Z_W'(signed'(resid));
            side0_reg <= side0_next;
        end
    end

    assign valid_vec[0] = valid0_reg;
    assign cx[0]        = x0_reg;
    assign cy[0]        = '0;
    assign cz[0]        = z0_reg;
    assign cs[0]        = side0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        lsp2c_cell #(
            .X_W  (X_W),
            .Z_W  (Z_W),
            .STEP (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .prev_valid (valid_vec[i]),
            .prev_x     (cx[i]),
            .prev_y     (cy[i]),
            .prev_z     (cz[i]),
            .prev_side  (cs[i]),
            .valid      (valid_vec[i+1]),
            .x          (cx[i+1]),
            .y          (cy[i+1]),
            .z          (cz[i+1]),
            .side       (cs[i+1])
        );
    end

    always_comb
    begin
        unique case (cs[CORDIC_STEPS].quadrant)
            2'd0:
            begin
                xr = cx[CORDIC_STEPS];
                yr = cy[CORDIC_STEPS];
            end
            2'd1:
            begin
                xr = -cy[CORDIC_STEPS];
                yr = cx[CORDIC_STEPS];
            end
            2'd2:
            begin
                xr = -cx[CORDIC_STEPS];
                yr = -cy[CORDIC_STEPS];
            end
            2'd3:
            begin
                xr = cy[CORDIC_STEPS];
                yr = -cx[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= valid_vec[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_out_reg     <= finish(xr);
            y_out_reg     <= finish(yr);
            inten_out_reg <= cs[CORDIC_STEPS].intensity;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({inten_out_reg, y_out_reg, x_out_reg});

    `LSP2C_ASSERT_NEXT(a_scan_restart, s_xfer && s_tuser[0], angle_reg == $past(start_angle + angle_step))
    `LSP2C_ASSERT_NEXT(a_window_drop, s_xfer && !in_window, !valid_vec[0])
    `LSP2C_ASSERT_NEXT(a_chain_hold, !adv, $stable(valid_vec))
    `LSP2C_ASSERT_SAME(a_out_source, $rose(m_valid_reg), $past(valid_vec[CORDIC_STEPS]))

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the laser scan polar to Cartesian converter.
module testbench;
    import lsp2c_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BEAMS = 1325;
    localparam longint COORD_MAX = 16777215;
    localparam longint COORD_MIN = -16777216;
    localparam longint BEAM_GAIN = 64'd2608131496;
    localparam longint ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic [15:0]        inten;
    } point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;   // range, intensity
    logic [0:0]            s_tuser;   // scan_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [71:0]           m_tdata;   // x_coord, y_coord, point_intensity
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    logic [23:0] cfg_min_range     = 24'h000000;
    logic [23:0] cfg_max_range     = 24'hFFFFFF;
    logic [31:0] cfg_start_angle   = 32'h0;
    logic [31:0] cfg_angle_step    = 32'h0;
    logic        cfg_use_intensity = 1'b0;
    logic [31:0] angle_acc         = 32'h0;

    point_t pending_points [$];
    int     error_count    = 0;
    int     beams_sent     = 0;
    int     points_checked = 0;
    int     settings_count = 0;
    int     quiet_cycles   = 0;
    int     src_idle_pct   = 0;
    int     snk_stall_pct  = 0;

    laser_scan_polar_to_cartesian dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [24:0] round_coord(input longint v);
        longint r;
        r = (v + 64'sd8388608) >>> 24;
        if (r > COORD_MAX)
            r = COORD_MAX;
        if (r < COORD_MIN)
            r = COORD_MIN;
        return r[24:0];
    endfunction

    // Advance the beam angle and rotate the range onto the x/y plane.
    function automatic bit beam_to_point(input logic start, input logic [23:0] range,
                                         input logic [15:0] inten, output point_t pt);
        logic [31:0] ang;
        logic [31:0] folded;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy, xr, yr;
        ang = start ? cfg_start_angle : angle_acc;
        angle_acc = ang + cfg_angle_step;
        pt = '0;
        if (range < cfg_min_range || range > cfg_max_range)
            return 1'b0;
        folded = ang + 32'h2000_0000;
        quad = folded[31:30];
        resid = ang - {quad, 30'b0};
        z = longint'($signed(resid));
        x = (longint'(range) * BEAM_GAIN) >>> 8;
        y = 0;
        for (int i = 0; i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
        end
        case (quad)
            2'd0:    begin xr = x;  yr = y;  end
            2'd1:    begin xr = -y; yr = x;  end
            2'd2:    begin xr = -x; yr = -y; end
            default: begin xr = y;  yr = -x; end
        endcase
        pt.x = round_coord(xr);
        pt.y = round_coord(yr);
        pt.inten = cfg_use_intensity ? inten : 16'h0;
        return 1'b1;
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [23:0] pick_range();
        case ($urandom_range(0, 9))
            5:       return 24'($urandom_range(0, 1023));
            6:       return cfg_min_range + 24'($urandom_range(0, 4)) - 24'd2;
            7:       return cfg_max_range + 24'($urandom_range(0, 4)) - 24'd2;
            8:       return $urandom_range(1) ? 24'hFFFFFF : 24'h0;
            9:       return 24'($urandom_range(cfg_max_range, cfg_min_range));
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        point_t pt;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (s_tvalid && s_tready)
            begin
                beams_sent++;
                if (beam_to_point(s_tuser[0], s_tdata[23:0], s_tdata[39:24], pt))
                    pending_points.insert(pending_points.size(), pt);
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_points.size() == 0)
                begin
                    $display("%0t ns: unexpected point, expected none, actual x=%0d y=%0d i=%0d",
                             $time, $signed(m_tdata[24:0]), $signed(m_tdata[49:25]),
                             m_tdata[65:50]);
                    error_count++;
                end
                else
                begin
                    pt = pending_points.pop_front();
                    compare_field("x_coord", pt.x, $signed(m_tdata[24:0]));
                    compare_field("y_coord", pt.y, $signed(m_tdata[49:25]));
                    compare_field("point_intensity", pt.inten, m_tdata[65:50]);
                    compare_field("tdata padding", 0, m_tdata[71:66]);
                    points_checked++;
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Random backpressure on the point stream.
    initial
    begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(99) < snk_stall_pct)
            begin
                hold = pick_gap(100) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_RANGE:     cfg_min_range = value[23:0];
            REG_MAX_RANGE:     cfg_max_range = value[23:0];
            REG_START_ANGLE:   cfg_start_angle = value;
            REG_ANGLE_STEP:    cfg_angle_step = value;
            REG_USE_INTENSITY: cfg_use_intensity = value[0];
            default:           ;
        endcase
    endtask

    task automatic set_config(input logic [23:0] lo_r, input logic [23:0] hi_r,
                              input logic [31:0] start, input logic [31:0] step,
                              input logic pass_inten, input bit junk);
        logic [31:0] noise;
        noise = junk ? $urandom() : 32'h0;
        write_reg(REG_MIN_RANGE, {noise[31:24], lo_r});
        write_reg(REG_MAX_RANGE, {noise[7:0], hi_r});
        write_reg(REG_START_ANGLE, start);
        write_reg(REG_ANGLE_STEP, step);
        write_reg(REG_USE_INTENSITY, {noise[31:1], pass_inten});
        settings_count++;
    endtask

    task automatic send_beam(input logic start, input logic [23:0] range,
                             input logic [15:0] inten);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {inten, range};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid, let every point drain, then let beams with no point clear the chain.
    task automatic wait_idle();
        int saved;
        s_tvalid <= 1'b0;
        saved = snk_stall_pct;
        snk_stall_pct = 0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        snk_stall_pct = saved;
    endtask

    task automatic test_reset_defaults();
        send_beam(1'b1, 24'h000000, 16'hFFFF);
        send_beam(1'b0, 24'hFFFFFF, 16'h0000);
        send_beam(1'b0, 24'h800000, 16'hA5A5);
        send_beam(1'b1, 24'h000001, 16'h0001);
    endtask

    task automatic test_range_window();
        wait_idle();
        set_config(24'd1000, 24'd2000, 32'h2000_0000, 32'h4000_0000, 1'b1, 1'b0);
        send_beam(1'b1, 24'd999, 16'h1234);
        send_beam(1'b0, 24'd1000, 16'hFFFF);
        send_beam(1'b0, 24'd2000, 16'h0000);
        send_beam(1'b0, 24'd2001, 16'h5A5A);
        send_beam(1'b0, 24'd1500, 16'h8001);
        wait_idle();
        set_config(24'd5000, 24'd4999, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_beam(1'b1, 24'd5000, 16'h1111);
        send_beam(1'b0, 24'd4999, 16'h2222);
        send_beam(1'b0, 24'd0, 16'h3333);
    endtask

    task automatic test_quadrants();
        wait_idle();
        set_config(24'h0, 24'hFFFFFF, 32'h8000_0000, 32'h2000_0000, 1'b1, 1'b0);
        for (int k = 0; k < 9; k++)
            send_beam(k == 0, 24'hFFFFFF, k[0] ? 16'hFFFF : 16'h0000);
        wait_idle();
        set_config(24'h0, 24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        send_beam(1'b1, 24'h000001, 16'hFFFF);
        send_beam(1'b0, 24'hFFFFFF, 16'hFFFF);
        send_beam(1'b0, 24'h555555, 16'hFFFF);
    endtask

    task automatic random_config();
        logic [23:0] a, b, lo_r, hi_r;
        logic [31:0] step;
        a = 24'($urandom());
        b = 24'($urandom());
        case ($urandom_range(0, 9))
            6:       begin lo_r = 24'h0; hi_r = 24'hFFFFFF; end
            7:       begin lo_r = (a < b) ? a : b; hi_r = (a < b) ? b : a; end
            8:       begin lo_r = (a < b) ? b : a; hi_r = (a < b) ? a : b; end
            9:       begin lo_r = $urandom_range(1) ? 24'hFFFFFF : 24'h0; hi_r = lo_r; end
            default: begin
                lo_r = 24'($urandom_range(0, 2000));
                hi_r = 24'hFFFFFF - 24'($urandom_range(0, 2000));
            end
        endcase
        case ($urandom_range(0, 6))
            0, 1:    step = $urandom();
            2:       step = $urandom_range(0, 1 << 24);
            3:       step = -32'($urandom_range(0, 1 << 24));
            4:       step = 32'h7FFF_FFFF;
            5:       step = 32'h8000_0000;
            default: step = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        set_config(lo_r, hi_r, $urandom(), step, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    endtask

    task automatic test_random_scans();
        int sent;
        int phase_end;
        int scan_len;
        int idle_pct [3] = '{0, 15, 40};
        sent = 0;
        while (sent < RANDOM_BEAMS)
        begin
            wait_idle();
            random_config();
            src_idle_pct = idle_pct[$urandom_range(0, 2)];
            snk_stall_pct = idle_pct[$urandom_range(0, 2)];
            phase_end = sent + $urandom_range(80, 200);
            while (sent < phase_end)
            begin
                scan_len = $urandom_range(1, 64);
                for (int k = 0; k < scan_len; k++)
                begin
                    send_beam(k == 0 || $urandom_range(39) == 0, pick_range(),
                              16'($urandom()));
                    sent++;
                end
            end
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_range_window();
        test_quadrants();
        test_random_scans();
        wait_idle();
        $display("testbench: %0d beams sent, %0d points checked, %0d register settings",
                 beams_sent, points_checked, settings_count);
        $display("testbench: covered reset defaults, range window edges, quadrants, random scans");
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ laser_scan_polar_to_cartesian.f @@
+incdir+design
design/lsp2c_pkg.sv
design/lsp2c_regs.sv
design/lsp2c_cell.sv
design/laser_scan_polar_to_cartesian.sv
tb/testbench.sv
